// File: design/ilrt_pkg.sv
// Shared types, codes and helper functions for the indexed list remove/transpose block.
// No dependencies; every other design file imports this package.
`default_nettype none

package ilrt_pkg;

   localparam int ENTRY_W         = 7;
   localparam int MAX_ENTRIES_DEF = 64;
   localparam int LIST_LEN_RESET  = 64;

   typedef logic [ENTRY_W-1:0] entry_type;

   // Operation codes carried in the op field of an input item.
   localparam logic OP_REMOVE = 1'b0;
   localparam logic OP_MOVE   = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;

   typedef struct packed {
      logic      op;
      entry_type target;
   } req_type;

   typedef struct packed {
      entry_type  entry;
      logic       is_last;
      logic       list_empty;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic      en;
      entry_type entry;
      entry_type data;
   } link_wr_type;

   typedef struct packed {
      logic      en;
      entry_type entry;
      entry_type dflt;
   } link_rd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_RM_WR,
      S_MV_RD,
      S_MV_WR1,
      S_MV_WR2,
      S_MV_WR3,
      S_WALK_START,
      S_WALK
   } state_type;

   // Forward link of entry e in a freshly built list of n entries.
   function automatic entry_type next_reset(entry_type e, entry_type n);
      return (e < n) ? entry_type'(e + entry_type'(1)) : '0;
   endfunction

   // Backward link of entry e in a freshly built list of n entries.
   function automatic entry_type prev_reset(entry_type e, entry_type n);
      return (e <= n) ? entry_type'(e - entry_type'(1)) : '0;
   endfunction

endpackage

`default_nettype wire

// File: design/ilrt_link_store.sv
// One link store: synchronous RAM with one write and one registered read port.
// Per-entry written bits let a rebuild forget every stored link. Depends on ilrt_pkg.
`default_nettype none

module ilrt_link_store
   import ilrt_pkg::*;
#(
   parameter int ENTRIES = MAX_ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        clear,
   input  wire link_wr_type wr,
   input  wire link_rd_type rd,
   output      entry_type   rd_data
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   entry_type          mem [ENTRIES];
   logic [ENTRIES-1:0] written_ff;
   logic [ENTRIES-1:0] written_in;
   entry_type          mem_q_ff;
   entry_type          dflt_ff;
   logic               hit_ff;
   entry_type          wr_m1;
   entry_type          rd_m1;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;

   // Entry numbers start at one.
   assign wr_m1   = wr.entry - entry_type'(1);
   assign rd_m1   = rd.entry - entry_type'(1);
   assign wr_addr = wr_m1[AW-1:0];
   assign rd_addr = rd_m1[AW-1:0];

   always_comb begin
      written_in = written_ff;
      if (wr.en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   // The sequencer never reads an entry in the cycle it writes it.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         mem_q_ff <= mem[rd_addr];
         hit_ff   <= written_ff[rd_addr];
         dflt_ff  <= rd.dflt;
      end
   end

   assign rd_data = hit_ff ? mem_q_ff : dflt_ff;

endmodule

`default_nettype wire

// File: design/indexed_list_remove_transpose_core.sv
// Top level of the indexed list remove/transpose block: sequencer, list state and output stage.
// Depends on ilrt_pkg and ilrt_link_store.
`default_nettype none

// Usage:
// The block holds a doubly linked list of entry numbers 1..list_length. A write on the
// csr_ channel sets list_length (saturated into 1..MAX_ENTRIES) and rebuilds the list in
// numeric order; csr_ready is high only while no item is in progress.
// Each item on the req_ channel either removes its target entry or swaps it with its
// predecessor. The block then sends the whole list, head to tail, on the rsp_ channel,
// one item per entry, with is_last on the final one. A bad target gives a single item
// carrying status and entry 0; moving the head entry changes nothing and sends nothing.
// One item is processed at a time. The walk over the forward link store reads one link per
// cycle while the output register can take a result. Results sit in an output register,
// so a stalled receiver holds the walk in place without losing anything. Reset restores
// the list of 64 entries (or MAX_ENTRIES if smaller), empties the output register and
// returns the sequencer to idle.
module indexed_list_remove_transpose_core
   import ilrt_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output      logic      req_ready,
   input  wire req_type   req_data,
   output      logic      rsp_valid,
   input  wire logic      rsp_ready,
   output      rsp_type   rsp_data,
   input  wire logic      csr_valid,
   output      logic      csr_ready,
   input  wire entry_type csr_data
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = AW;
   localparam entry_type LEN_RST = entry_type'((LIST_LEN_RESET > MAX_ENTRIES) ?
                                               MAX_ENTRIES : LIST_LEN_RESET);

   // Clamp a written length into the supported range.
   function automatic entry_type saturate_len(entry_type v);
      if (v == '0) begin
         return entry_type'(1);
      end
      if (v > entry_type'(MAX_ENTRIES)) begin
         return entry_type'(MAX_ENTRIES);
      end
      return v;
   endfunction

   // Membership flags of a freshly built list of n entries.
   function automatic logic [MAX_ENTRIES-1:0] presence_mask(entry_type n);
      logic [MAX_ENTRIES-1:0] m;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         m[i] = (entry_type'(i) < n);
      end
      return m;
   endfunction

   // Control state.
   state_type              state_ff, state_in;
   entry_type              head_ff, head_in;
   entry_type              len_ff, len_in;
   logic [MAX_ENTRIES-1:0] in_list_ff, in_list_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   entry_type              tgt_ff, tgt_in;
   logic [1:0]             err_status_ff, err_status_in;
   entry_type              p_ff, p_in;
   entry_type              n_ff, n_in;
   entry_type              cur_ff, cur_in;
   rsp_type                rsp_ff, rsp_in;

   // Link store ports.
   link_wr_type            next_wr, prev_wr;
   link_rd_type            next_rd, prev_rd;
   entry_type              next_rd_data, prev_rd_data;
   logic                   store_clear;

   logic                   req_fire, csr_fire, slot_free;
   logic                   range_bad, absent, walk_last;
   logic                   emit;
   rsp_type                emit_item;
   entry_type              req_m1, tgt_m1;
   logic [AW-1:0]          req_idx, tgt_idx;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign req_m1    = req_data.target - entry_type'(1);
   assign req_idx   = req_m1[AW-1:0];
   assign tgt_m1    = tgt_ff - entry_type'(1);
   assign tgt_idx   = tgt_m1[AW-1:0];
   assign range_bad = (req_data.target == '0) || (req_data.target > len_ff);
   assign absent    = !in_list_ff[req_idx];
   assign walk_last = (next_rd_data == '0) || (cnt_ff == CW'(MAX_ENTRIES - 1));

   // A length write or reset rebuilds the list by forgetting every stored link.
   assign store_clear = reset || csr_fire;

   ilrt_link_store #(
      .ENTRIES (MAX_ENTRIES)
   ) u_next_store (
      .clock   (clock),
      .clear   (store_clear),
      .wr      (next_wr),
      .rd      (next_rd),
      .rd_data (next_rd_data)
   );

   ilrt_link_store #(
      .ENTRIES (MAX_ENTRIES)
   ) u_prev_store (
      .clock   (clock),
      .clear   (store_clear),
      .wr      (prev_wr),
      .rd      (prev_rd),
      .rd_data (prev_rd_data)
   );

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (range_bad || absent) begin
                  state_in = S_ERR;
               end else if (req_data.op == OP_MOVE && head_ff == req_data.target) begin
                  state_in = S_IDLE;
               end else if (req_data.op == OP_REMOVE) begin
                  state_in = S_RM_WR;
               end else begin
                  state_in = S_MV_RD;
               end
            end
         end
         S_ERR: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         S_RM_WR:  state_in = S_WALK_START;
         S_MV_RD:  state_in = S_MV_WR1;
         S_MV_WR1: state_in = S_MV_WR2;
         S_MV_WR2: state_in = S_MV_WR3;
         S_MV_WR3: state_in = S_WALK_START;
         S_WALK_START: begin
            if (head_ff != '0) begin
               state_in = S_WALK;
            end else if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (slot_free && walk_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshakes, link store accesses and result items.
   always_comb begin
      req_ready = 1'b0;
      csr_ready = 1'b0;
      next_wr   = '0;
      prev_wr   = '0;
      next_rd   = '0;
      prev_rd   = '0;
      emit      = 1'b0;
      emit_item = '0;
      case (state_ff)
         S_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (req_fire && !range_bad && !absent) begin
               next_rd = '{en: 1'b1, entry: req_data.target,
                           dflt: next_reset(req_data.target, len_ff)};
               prev_rd = '{en: 1'b1, entry: req_data.target,
                           dflt: prev_reset(req_data.target, len_ff)};
            end
         end
         S_ERR: begin
            emit      = slot_free;
            emit_item = '{entry: '0, is_last: 1'b1, list_empty: (head_ff == '0),
                          status: err_status_ff};
         end
         S_RM_WR: begin
            // Unlink the target: its predecessor and follower point at each other.
            if (prev_rd_data != '0) begin
               next_wr = '{en: 1'b1, entry: prev_rd_data, data: next_rd_data};
            end
            if (next_rd_data != '0) begin
               prev_wr = '{en: 1'b1, entry: next_rd_data, data: prev_rd_data};
            end
         end
         S_MV_RD: begin
            // The target is not the head, so its predecessor exists.
            prev_rd = '{en: 1'b1, entry: prev_rd_data,
                        dflt: prev_reset(prev_rd_data, len_ff)};
         end
         S_MV_WR1: begin
            // Second predecessor now leads to the target.
            if (prev_rd_data != '0) begin
               next_wr = '{en: 1'b1, entry: prev_rd_data, data: tgt_ff};
            end
            prev_wr = '{en: 1'b1, entry: tgt_ff, data: prev_rd_data};
         end
         S_MV_WR2: begin
            next_wr = '{en: 1'b1, entry: tgt_ff, data: p_ff};
            prev_wr = '{en: 1'b1, entry: p_ff, data: tgt_ff};
         end
         S_MV_WR3: begin
            next_wr = '{en: 1'b1, entry: p_ff, data: n_ff};
            if (n_ff != '0) begin
               prev_wr = '{en: 1'b1, entry: n_ff, data: p_ff};
            end
         end
         S_WALK_START: begin
            if (head_ff == '0) begin
               emit      = slot_free;
               emit_item = '{entry: '0, is_last: 1'b1, list_empty: 1'b1, status: ST_OK};
            end else begin
               next_rd = '{en: 1'b1, entry: head_ff, dflt: next_reset(head_ff, len_ff)};
            end
         end
         S_WALK: begin
            emit      = slot_free;
            emit_item = '{entry: cur_ff, is_last: walk_last, list_empty: 1'b0,
                          status: ST_OK};
            if (slot_free && !walk_last) begin
               next_rd = '{en: 1'b1, entry: next_rd_data,
                           dflt: next_reset(next_rd_data, len_ff)};
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Next values of the list state and working registers.
   always_comb begin
      head_in       = head_ff;
      len_in        = len_ff;
      in_list_in    = in_list_ff;
      cnt_in        = cnt_ff;
      tgt_in        = tgt_ff;
      err_status_in = err_status_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      cur_in        = cur_ff;

      if (csr_fire) begin
         len_in     = saturate_len(csr_data);
         in_list_in = presence_mask(saturate_len(csr_data));
         head_in    = entry_type'(1);
      end

      if (req_fire) begin
         tgt_in        = req_data.target;
         err_status_in = range_bad ? ST_RANGE : ST_ABSENT;
      end

      case (state_ff)
         S_RM_WR: begin
            in_list_in[tgt_idx] = 1'b0;
            if (prev_rd_data == '0) begin
               head_in = next_rd_data;
            end
         end
         S_MV_RD: begin
            p_in = prev_rd_data;
            n_in = next_rd_data;
         end
         S_MV_WR1: begin
            if (prev_rd_data == '0) begin
               head_in = tgt_ff;
            end
         end
         S_WALK_START: begin
            cur_in = head_ff;
            cnt_in = '0;
         end
         S_WALK: begin
            if (slot_free && !walk_last) begin
               cur_in = next_rd_data;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   // Output register: holds one result item while the receiver stalls.
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = emit ? emit_item : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= entry_type'(1);
         len_ff       <= LEN_RST;
         in_list_ff   <= presence_mask(LEN_RST);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         len_ff       <= len_in;
         in_list_ff   <= in_list_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff        <= tgt_in;
      err_status_ff <= err_status_in;
      p_ff          <= p_in;
      n_ff          <= n_in;
      cur_ff        <= cur_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   entry_type     head_m1;
   logic [AW-1:0] head_idx;

   assign head_m1  = head_ff - entry_type'(1);
   assign head_idx = head_m1[AW-1:0];

   // Only the final item of a walk may carry an error or the empty flag.
   a_mid_walk_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_last) |-> (rsp_data.status == ST_OK && !rsp_data.list_empty))
      else $error("non-final result item carries status or empty flag");

   // An error item never names an entry and always ends the operation.
   a_error_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.entry == '0 && rsp_data.is_last))
      else $error("error result item is malformed");

   // Between operations a nonzero head must be a member of the list.
   a_head_member: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && head_ff != '0) |-> in_list_ff[head_idx])
      else $error("list head is not a member of the list");

   // A length write leaves a length inside the supported range.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> (len_ff != '0 && len_ff <= entry_type'(MAX_ENTRIES) && head_ff == entry_type'(1)))
      else $error("length write left an unsupported list state");
`endif

endmodule

`default_nettype wire
